/* sv/bswq_pkg.sv */
package bswq_pkg;

    localparam int DEF_MAX_THREADS = 8;
    localparam int TID_W           = 3;
    localparam int OUTCOME_W       = 3;
    localparam int COUNT_OUT_W     = 4;

    typedef enum logic [0:0] {
        OP_WAIT = 1'b0,
        OP_POST = 1'b1
    } t_opcode;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_GRANTED = 3'd0,
        OUT_BLOCKED = 3'd1,
        OUT_SET     = 3'd2,
        OUT_WOKEN   = 3'd3,
        OUT_FULL    = 3'd4
    } t_outcome;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_cmd;

endpackage

/* sv/binary_semaphore_wait_queue.sv */
// Binary semaphore with a first-in first-out queue of blocked thread ids. An item is accepted
// when start is high and busy is low; each item first reads the oldest waiter's slot from the
// queue memory, as it is accepted, and then updates the state, and its result appears on
// the output ports for exactly one cycle with o_done high, in the cycle after the update. The
// receiver cannot stall, so every result must be taken in the cycle in which it is shown. A
// new item may be started in the cycle in which the previous result is shown. The initial
// value register is always ready and loads the semaphore value at once; write it only while idle.
module binary_semaphore_wait_queue #(
    parameter int MAX_THREADS = bswq_pkg::DEF_MAX_THREADS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic [bswq_pkg::TID_W-1:0]          i_thread_id,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    output logic                                o_done,
    output logic [bswq_pkg::OUTCOME_W-1:0]      o_outcome,
    output logic [bswq_pkg::TID_W-1:0]          o_woken_thread,
    output logic                                o_sem_value,
    output logic [bswq_pkg::COUNT_OUT_W-1:0]    o_waiter_count
);
    import bswq_pkg::*;

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    bswq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    bswq_dpath #(
        .MAX_THREADS (MAX_THREADS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_opcode       (i_opcode),
        .i_thread_id    (i_thread_id),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_outcome      (o_outcome),
        .o_woken_thread (o_woken_thread),
        .o_sem_value    (o_sem_value),
        .o_waiter_count (o_waiter_count)
    );

endmodule

/* sv/bswq_ctrl.sv */
module bswq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output bswq_pkg::t_cmd o_cmd
);
    import bswq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && start;
    assign o_cmd.exec   = (r_state == S_EXEC);

endmodule

/* sv/bswq_dpath.sv */
module bswq_dpath #(
    parameter int MAX_THREADS = bswq_pkg::DEF_MAX_THREADS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bswq_pkg::t_cmd                      i_cmd,
    input  logic                                i_opcode,
    input  logic [bswq_pkg::TID_W-1:0]          i_thread_id,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_data,
    output logic                                o_done,
    output logic [bswq_pkg::OUTCOME_W-1:0]      o_outcome,
    output logic [bswq_pkg::TID_W-1:0]          o_woken_thread,
    output logic                                o_sem_value,
    output logic [bswq_pkg::COUNT_OUT_W-1:0]    o_waiter_count
);
    import bswq_pkg::*;

    localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);

    logic [TID_W-1:0] r_ring [MAX_THREADS];
    logic [TID_W-1:0] r_rd_data;

    logic             r_op;
    logic [TID_W-1:0] r_tid;
    logic             r_value;
    logic [IW-1:0]    r_head;
    logic [IW-1:0]    r_tail;
    logic [CW-1:0]    r_count;

    logic             n_value;
    logic [IW-1:0]    n_head;
    logic [IW-1:0]    n_tail;
    logic [CW-1:0]    n_count;
    t_outcome         n_outcome;
    logic [TID_W-1:0] n_woken;
    logic             n_ring_we;

    logic                 r_done;
    t_outcome             r_outcome;
    logic [TID_W-1:0]     r_woken;
    logic                 r_sem;
    logic [CW+COUNT_OUT_W-1:0] r_count_wide;

    always_comb begin
        n_value   = r_value;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_outcome = OUT_SET;
        n_woken   = '0;
        n_ring_we = 1'b0;
        if (r_op == OP_WAIT) begin
            if (r_value) begin
                n_value   = 1'b0;
                n_outcome = OUT_GRANTED;
            end else if (r_count == CW'(MAX_THREADS)) begin
                n_outcome = OUT_FULL;
            end else begin
                n_ring_we = 1'b1;
                n_tail    = (r_tail == IW'(MAX_THREADS - 1)) ? '0 : r_tail + 1'b1;
                n_count   = r_count + 1'b1;
                n_outcome = OUT_BLOCKED;
            end
        end else begin
            if (!r_value && (r_count != '0)) begin
                n_woken   = r_rd_data;
                n_head    = (r_head == IW'(MAX_THREADS - 1)) ? '0 : r_head + 1'b1;
                n_count   = r_count - 1'b1;
                n_outcome = OUT_WOKEN;
            end else begin
                n_value   = 1'b1;
                n_outcome = OUT_SET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_ring_we) begin
            r_ring[r_tail] <= r_tid;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_ring[r_head];
            r_op      <= i_opcode;
            r_tid     <= i_thread_id;
        end
        if (i_cmd.exec) begin
            r_outcome    <= n_outcome;
            r_woken      <= n_woken;
            r_sem        <= n_value;
            r_count_wide <= {{COUNT_OUT_W{1'b0}}, n_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= 1'b1;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cfg_valid) begin
                r_value <= i_cfg_data;
            end else if (i_cmd.exec) begin
                r_value <= n_value;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    assign o_done         = r_done;
    assign o_outcome      = r_outcome;
    assign o_woken_thread = r_woken;
    assign o_sem_value    = r_sem;
    assign o_waiter_count = r_count_wide[COUNT_OUT_W-1:0];

endmodule
